[rtl/dsdop_pkg.sv]
// Shared types and constants for the delta-sigma DoP encoder.
package dsdop_pkg;

    // Loop order and DoP word layout
    localparam int ORDER     = 4;
    localparam int DSD_BITS  = 16;
    localparam int MARK_W    = 8;
    localparam int DOP_W     = MARK_W + DSD_BITS;
    localparam int COUNT_W   = $clog2(DSD_BITS);

    // Marker bytes, alternating from reset
    localparam logic [MARK_W-1:0] MARK_FIRST  = 8'h05;
    localparam logic [MARK_W-1:0] MARK_SECOND = 8'hFA;

    // Quantizer feedback held between requests
    typedef enum logic [1:0] {
        FB_NONE = 2'd0,
        FB_POS  = 2'd1,
        FB_NEG  = 2'd2
    } fb_t;

    // New DSD bit of each lane, handed to the packer
    typedef struct packed {
        logic left;
        logic right;
    } lane_bits_t;

endpackage

[rtl/dsdop_lane.sv]
// One channel of the four-integrator one-bit delta-sigma loop.
module dsdop_lane #(
    parameter int ACC_WIDTH    = 32,
    parameter int SAMPLE_WIDTH = 24
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           step,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    output logic                           dsd_bit
);
    import dsdop_pkg::*;

    localparam int MAX_W = (ACC_WIDTH > SAMPLE_WIDTH) ? ACC_WIDTH : SAMPLE_WIDTH;
    localparam int SUM_W = MAX_W + 2;

    localparam logic signed [SUM_W-1:0] FULL_SCALE =
        {{(SUM_W-SAMPLE_WIDTH){1'b0}}, 1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    localparam logic [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam logic [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

    logic signed [ACC_WIDTH-1:0] integ_reg  [ORDER];
    logic signed [ACC_WIDTH-1:0] integ_next [ORDER];
    fb_t                         fb_reg;
    fb_t                         fb_next;
    logic signed [SUM_W-1:0]     fb_val;
    logic signed [SUM_W-1:0]     sample_ext;

    // Clamp an exact sum to the accumulator range
    function automatic logic [ACC_WIDTH-1:0] sat_acc(input logic [SUM_W-1:0] v);
        logic fits;
        fits = (&v[SUM_W-1:ACC_WIDTH-1]) | ~(|v[SUM_W-1:ACC_WIDTH-1]);
        if (fits) begin
            return v[ACC_WIDTH-1:0];
        end
        return v[SUM_W-1] ? ACC_MIN : ACC_MAX;
    endfunction

    // Decode the previous quantizer output into its feedback value
    always_comb begin
        unique case (fb_reg)
            FB_POS:  fb_val = FULL_SCALE;
            FB_NEG:  fb_val = -FULL_SCALE;
            default: fb_val = '0;
        endcase
    end

    assign sample_ext = {{(SUM_W-SAMPLE_WIDTH){sample[SAMPLE_WIDTH-1]}}, sample};

    // Ripple the sample through the integrator cascade
    always_comb begin
        logic signed [SUM_W-1:0] stage_in;
        logic signed [SUM_W-1:0] acc_ext;
        for (int k = 0; k < ORDER; k++) begin
            if (k == 0) begin
                stage_in = sample_ext;
            end else begin
                stage_in = {{(SUM_W-ACC_WIDTH){integ_next[k-1][ACC_WIDTH-1]}},
                            integ_next[k-1]};
            end
            acc_ext = {{(SUM_W-ACC_WIDTH){integ_reg[k][ACC_WIDTH-1]}}, integ_reg[k]};
            integ_next[k] = sat_acc(acc_ext + stage_in - fb_val);
        end
    end

    // Quantize the last integrator
    assign dsd_bit = ~integ_next[ORDER-1][ACC_WIDTH-1];
    assign fb_next = dsd_bit ? FB_POS : FB_NEG;

    // Advance the loop state on each request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < ORDER; k++) begin
                integ_reg[k] <= '0;
            end
            fb_reg <= FB_NONE;
        end else if (step) begin
            for (int k = 0; k < ORDER; k++) begin
                integ_reg[k] <= integ_next[k];
            end
            fb_reg <= fb_next;
        end
    end

endmodule

[rtl/dsdop_pack.sv]
// Merge the lane bits into DoP words and hold them in the output register.
module dsdop_pack (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  dsdop_pkg::lane_bits_t               lane_bits,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [dsdop_pkg::DOP_W-1:0]         m_dop_left,
    output logic [dsdop_pkg::DOP_W-1:0]         m_dop_right
);
    import dsdop_pkg::*;

    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  count_next;
    logic [DSD_BITS-2:0] bits_left_reg;
    logic [DSD_BITS-2:0] bits_right_reg;
    logic                phase_reg;
    logic                phase_next;
    logic                valid_reg;
    logic                valid_next;
    logic [DOP_W-1:0]    dop_left_reg;
    logic [DOP_W-1:0]    dop_right_reg;
    logic [MARK_W-1:0]   mark;
    logic                last;
    logic                accept;

    // Stall only when a finished word meets a full output register
    assign last    = (count_reg == COUNT_W'(DSD_BITS-1));
    assign s_ready = !last || !valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign mark    = phase_reg ? MARK_SECOND : MARK_FIRST;

    // Next count, marker phase and output valid
    always_comb begin
        count_next = count_reg;
        phase_next = phase_reg;
        valid_next = valid_reg;
        if (m_ready) begin
            valid_next = 1'b0;
        end
        if (accept) begin
            count_next = COUNT_W'(count_reg + 1'b1);
            if (last) begin
                phase_next = !phase_reg;
                valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            phase_reg <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            phase_reg <= phase_next;
            valid_reg <= valid_next;
        end
    end

    // Shift in the new bits; load a word on the sixteenth bit
    always_ff @(posedge aclk) begin
        if (accept) begin
            bits_left_reg  <= {bits_left_reg[DSD_BITS-3:0], lane_bits.left};
            bits_right_reg <= {bits_right_reg[DSD_BITS-3:0], lane_bits.right};
            if (last) begin
                dop_left_reg  <= {mark, bits_left_reg, lane_bits.left};
                dop_right_reg <= {mark, bits_right_reg, lane_bits.right};
            end
        end
    end

    assign m_valid     = valid_reg;
    assign m_dop_left  = dop_left_reg;
    assign m_dop_right = dop_right_reg;

endmodule

[rtl/delta_sigma_dop_encoder_top.sv]
// Stereo one-bit delta-sigma modulator with DoP word packing, top level.
// Throughput: one sample request per cycle unless the input is stalled; each lane's four-integrator
//   loop is combinational between its registers, which sets the clock rate.
// A DoP word is registered and appears on the result port in the cycle after its 16th sample.
// Input stalls only when a 16th sample meets an output word not yet taken.
// Reset (synchronous, active low) clears integrators, feedback, bit count and marker.
module delta_sigma_dop_encoder_top #(
    parameter int ACC_WIDTH    = 32,
    parameter int SAMPLE_WIDTH = 24
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] s_sample_left,
    input  logic signed [SAMPLE_WIDTH-1:0] s_sample_right,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [dsdop_pkg::DOP_W-1:0]    m_dop_left,
    output logic [dsdop_pkg::DOP_W-1:0]    m_dop_right
);
    import dsdop_pkg::*;

    logic       step;
    lane_bits_t lane_bits;

    assign step = s_valid && s_ready;

    // Left and right loops run side by side
    dsdop_lane #(
        .ACC_WIDTH    (ACC_WIDTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_lane_left (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .sample  (s_sample_left),
        .dsd_bit (lane_bits.left)
    );

    dsdop_lane #(
        .ACC_WIDTH    (ACC_WIDTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_lane_right (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .sample  (s_sample_right),
        .dsd_bit (lane_bits.right)
    );

    // Pack both lanes into DoP words
    dsdop_pack u_pack (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .lane_bits   (lane_bits),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_dop_left  (m_dop_left),
        .m_dop_right (m_dop_right)
    );

    // A word is only produced by an accepted request
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready))
        else $error("result appeared without an accepted request");

    // Both channels carry the same valid marker
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_dop_left[DOP_W-1:DSD_BITS] == m_dop_right[DOP_W-1:DSD_BITS]) &&
                    ((m_dop_left[DOP_W-1:DSD_BITS] == MARK_FIRST) ||
                     (m_dop_left[DOP_W-1:DSD_BITS] == MARK_SECOND)))
        else $error("bad DoP marker");

    // A word following a taken word carries the other marker
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready) |=>
            (!m_valid || (m_dop_left[DOP_W-1:DSD_BITS] !=
                          $past(m_dop_left[DOP_W-1:DSD_BITS]))))
        else $error("marker did not alternate");

endmodule
